/* rtl/pra_pkg.sv */
// ----------------------------------------------------------------------------
// pra_pkg
// Shared widths, constants, payload types and the arctangent table for the
// point rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 18;
  localparam int ANGLE_WIDTH   = 16;

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = ((4 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

  // datapath widths
  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int XY_W      = 34;
  localparam int Z_W       = 33;
  localparam int TURN_W    = 32;
  localparam int ANG_EXT_W = ANGLE_WIDTH + 2;
  localparam int RED_W     = 15;
  localparam int STEP_W    = 18;
  localparam int REM_W     = 21;
  localparam int RECIP_W   = 21;
  localparam int QUO_W     = 14;
  localparam int IDX_W     = 5;
  localparam int PROD_W    = DIFF_W + XY_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int FRAC_W    = 30;
  localparam int RND_W     = SUM_W - FRAC_W;
  localparam int OUT_W     = RND_W + 1;

  // one full turn is 23040 units of 1/64 degree
  localparam logic signed [ANG_EXT_W-1:0] ANG_FULL = ANG_EXT_W'(23040);

  // theta = r * ANG_STEP + floor((r * REM_MUL + REM_ADD) / 90)
  localparam logic [STEP_W-1:0]  ANG_STEP    = STEP_W'(186413);
  localparam logic [REM_W-1:0]   REM_MUL     = REM_W'(46);
  localparam logic [REM_W-1:0]   REM_ADD     = REM_W'(45);
  // ceil(2^27 / 90), exact over the range of the remainder argument
  localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(1491309);
  localparam int                 RECIP_SHIFT = 27;

  // inverse cordic gain in Q1.30
  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(32'h26DD3B6A);

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_W - 1);

  localparam logic signed [OUT_W-1:0] COORD_MAX = OUT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [OUT_W-1:0] COORD_MIN = OUT_W'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  // payload that rides along with the angle through the cordic stages
  typedef struct packed {
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
  } side_t;

  // atan(2^-idx) as a fraction of a full turn, 2^32 per turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [TURN_W-1:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/point_rotate_about_center.sv */
// Depth: 24 register stages, all of which hold while the output side stalls.
// Throughput: one transaction per cycle when the output side does not stall;
// the depth is set by the three angle stages, one stage per cordic
// micro-rotation and three product/sum/clamp stages.
// Reset: rst_ni clears every valid bit at once; the pipeline is then empty.
// ----------------------------------------------------------------------------
// point_rotate_about_center
// Rotates a Q15.8 point about a center by an angle in 1/64 degree units,
// using a gain-compensated pipelined cordic, with saturation of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_about_center (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_x, point_y, center_x, center_y, angle_deg
  input  wire  [pra_pkg::S_DATA_W-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // rotated_x, rotated_y
  output logic [pra_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // saturated
  output logic [0:0]                       m_axis_tuser
);

  localparam int CW = pra_pkg::COORD_WIDTH;
  localparam int NS = pra_pkg::CORDIC_STAGES;

  logic en;
  logic signed [CW-1:0] px, py, cx, cy;
  logic signed [pra_pkg::ANGLE_WIDTH-1:0] angle;

  // whole pipeline moves unless a finished result is waiting
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign px    = s_axis_tdata[0*CW +: CW];
  assign py    = s_axis_tdata[1*CW +: CW];
  assign cx    = s_axis_tdata[2*CW +: CW];
  assign cy    = s_axis_tdata[3*CW +: CW];
  assign angle = s_axis_tdata[4*CW +: pra_pkg::ANGLE_WIDTH];

  logic                            cv   [NS+1];
  logic signed [pra_pkg::XY_W-1:0] cxv  [NS+1];
  logic signed [pra_pkg::XY_W-1:0] cyv  [NS+1];
  logic signed [pra_pkg::Z_W-1:0]  czv  [NS+1];
  pra_pkg::side_t                  csd  [NS+1];

  pra_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .px_i    (px),
    .py_i    (py),
    .cx_i    (cx),
    .cy_i    (cy),
    .angle_i (angle),
    .valid_o (cv[0]),
    .z_o     (czv[0]),
    .side_o  (csd[0])
  );

  assign cxv[0] = pra_pkg::INV_GAIN;
  assign cyv[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    pra_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (pra_pkg::IDX_W'(i)),
      .valid_i (cv[i]),
      .x_i     (cxv[i]),
      .y_i     (cyv[i]),
      .z_i     (czv[i]),
      .side_i  (csd[i]),
      .valid_o (cv[i+1]),
      .x_o     (cxv[i+1]),
      .y_o     (cyv[i+1]),
      .z_o     (czv[i+1]),
      .side_o  (csd[i+1])
    );
  end

  logic signed [CW-1:0] rx, ry;
  logic                 sat;

  pra_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[NS]),
    .cos_i   (cxv[NS]),
    .sin_i   (cyv[NS]),
    .side_i  (csd[NS]),
    .valid_o (m_axis_tvalid),
    .rx_o    (rx),
    .ry_o    (ry),
    .sat_o   (sat)
  );

  assign m_axis_tdata = pra_pkg::M_DATA_W'({ry, rx});
  assign m_axis_tuser = sat;

endmodule

`default_nettype wire

/* rtl/pra_angle.sv */
// ----------------------------------------------------------------------------
// pra_angle
// Three-stage front end: wraps the angle into one turn, maps it to a 32-bit
// binary angle, folds it into the right half plane and forms the offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_angle (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           en_i,
  input  wire                                           valid_i,
  input  wire  logic signed [pra_pkg::COORD_WIDTH-1:0]  px_i,
  input  wire  logic signed [pra_pkg::COORD_WIDTH-1:0]  py_i,
  input  wire  logic signed [pra_pkg::COORD_WIDTH-1:0]  cx_i,
  input  wire  logic signed [pra_pkg::COORD_WIDTH-1:0]  cy_i,
  input  wire  logic signed [pra_pkg::ANGLE_WIDTH-1:0]  angle_i,
  output logic                                          valid_o,
  output logic signed [pra_pkg::Z_W-1:0]                z_o,
  output pra_pkg::side_t                                side_o
);

  // stage 1: wrap into [0, full turn) and form offsets
  logic                                    v1_q;
  logic [pra_pkg::RED_W-1:0]               red_d, red_q;
  pra_pkg::side_t                          side1_d, side1_q;
  logic signed [pra_pkg::ANG_EXT_W-1:0]    ang_ext, ang_p1, ang_p2, ang_m1;

  always_comb begin
    ang_ext = pra_pkg::ANG_EXT_W'(angle_i);
    ang_p1  = ang_ext + pra_pkg::ANG_FULL;
    ang_p2  = ang_p1 + pra_pkg::ANG_FULL;
    ang_m1  = ang_ext - pra_pkg::ANG_FULL;
    if (ang_ext >= pra_pkg::ANG_FULL) begin
      red_d = pra_pkg::RED_W'(ang_m1);
    end else if (!ang_ext[pra_pkg::ANG_EXT_W-1]) begin
      red_d = pra_pkg::RED_W'(ang_ext);
    end else if (!ang_p1[pra_pkg::ANG_EXT_W-1]) begin
      red_d = pra_pkg::RED_W'(ang_p1);
    end else begin
      red_d = pra_pkg::RED_W'(ang_p2);
    end
    side1_d.dx = pra_pkg::DIFF_W'(px_i) - pra_pkg::DIFF_W'(cx_i);
    side1_d.dy = pra_pkg::DIFF_W'(py_i) - pra_pkg::DIFF_W'(cy_i);
    side1_d.cx = cx_i;
    side1_d.cy = cy_i;
  end

  // stage 2: integer part of the scale and the rounded remainder quotient
  logic                                         v2_q;
  logic [pra_pkg::TURN_W-1:0]                   step_d, step_q;
  logic [pra_pkg::QUO_W-1:0]                    quo_d, quo_q;
  logic [pra_pkg::RED_W+pra_pkg::STEP_W-1:0]    step_full;
  logic [pra_pkg::REM_W-1:0]                    rem_arg;
  logic [pra_pkg::REM_W+pra_pkg::RECIP_W-1:0]   recip_full;
  pra_pkg::side_t                               side2_q;

  always_comb begin
    step_full  = (pra_pkg::RED_W + pra_pkg::STEP_W)'(red_q)
               * (pra_pkg::RED_W + pra_pkg::STEP_W)'(pra_pkg::ANG_STEP);
    step_d     = step_full[pra_pkg::TURN_W-1:0];
    rem_arg    = pra_pkg::REM_W'(red_q) * pra_pkg::REM_MUL + pra_pkg::REM_ADD;
    recip_full = (pra_pkg::REM_W + pra_pkg::RECIP_W)'(rem_arg)
               * (pra_pkg::REM_W + pra_pkg::RECIP_W)'(pra_pkg::RECIP);
    quo_d      = recip_full[pra_pkg::RECIP_SHIFT +: pra_pkg::QUO_W];
  end

  // stage 3: binary angle, half-plane fold, offsets negated on a fold
  logic                          v3_q;
  logic [pra_pkg::TURN_W-1:0]    theta, theta_f;
  logic                          flip;
  logic signed [pra_pkg::Z_W-1:0] z_d, z_q;
  pra_pkg::side_t                side3_d, side3_q;

  always_comb begin
    theta   = step_q + pra_pkg::TURN_W'(quo_q);
    // second and third quadrant: add half a turn and negate the offsets
    flip    = theta[pra_pkg::TURN_W-1] ^ theta[pra_pkg::TURN_W-2];
    theta_f = {theta[pra_pkg::TURN_W-1] ^ flip, theta[pra_pkg::TURN_W-2:0]};
    z_d     = pra_pkg::Z_W'(signed'(theta_f));
    side3_d = side2_q;
    if (flip) begin
      side3_d.dx = -side2_q.dx;
      side3_d.dy = -side2_q.dy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      side1_q <= side1_d;
      step_q  <= step_d;
      quo_q   <= quo_d;
      side2_q <= side1_q;
      z_q     <= z_d;
      side3_q <= side3_d;
    end
  end

  assign valid_o = v3_q;
  assign z_o     = z_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

/* rtl/pra_cordic_stage.sv */
// ----------------------------------------------------------------------------
// pra_cordic_stage
// One registered micro-rotation of the rotation-mode cordic; the side
// payload is carried along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_cordic_stage (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  wire  logic [pra_pkg::IDX_W-1:0]        idx_i,
  input  wire                                    valid_i,
  input  wire  logic signed [pra_pkg::XY_W-1:0]  x_i,
  input  wire  logic signed [pra_pkg::XY_W-1:0]  y_i,
  input  wire  logic signed [pra_pkg::Z_W-1:0]   z_i,
  input  wire  pra_pkg::side_t                   side_i,
  output logic                                   valid_o,
  output logic signed [pra_pkg::XY_W-1:0]        x_o,
  output logic signed [pra_pkg::XY_W-1:0]        y_o,
  output logic signed [pra_pkg::Z_W-1:0]         z_o,
  output pra_pkg::side_t                         side_o
);

  logic                            valid_q;
  logic signed [pra_pkg::XY_W-1:0] x_d, x_q, y_d, y_q, tx, ty;
  logic signed [pra_pkg::Z_W-1:0]  z_d, z_q, at;
  pra_pkg::side_t                  side_q;

  always_comb begin
    tx = y_i >>> idx_i;
    ty = x_i >>> idx_i;
    at = signed'(pra_pkg::Z_W'(pra_pkg::atan_turn(idx_i)));
    if (!z_i[pra_pkg::Z_W-1]) begin
      x_d = x_i - tx;
      y_d = y_i + ty;
      z_d = z_i - at;
    end else begin
      x_d = x_i + tx;
      y_d = y_i - ty;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

/* rtl/pra_combine.sv */
// ----------------------------------------------------------------------------
// pra_combine
// Back end: offset-by-cosine/sine products, rounded sums, center add and
// clamp into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_combine (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    en_i,
  input  wire                                    valid_i,
  input  wire  logic signed [pra_pkg::XY_W-1:0]  cos_i,
  input  wire  logic signed [pra_pkg::XY_W-1:0]  sin_i,
  input  wire  pra_pkg::side_t                   side_i,
  output logic                                   valid_o,
  output logic signed [pra_pkg::COORD_WIDTH-1:0] rx_o,
  output logic signed [pra_pkg::COORD_WIDTH-1:0] ry_o,
  output logic                                   sat_o
);

  // stage 1: four products
  logic                              v1_q;
  logic signed [pra_pkg::PROD_W-1:0] pxc_d, pys_d, pxs_d, pyc_d;
  logic signed [pra_pkg::PROD_W-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [pra_pkg::COORD_WIDTH-1:0] cx1_q, cy1_q;

  always_comb begin
    pxc_d = pra_pkg::PROD_W'(side_i.dx) * pra_pkg::PROD_W'(cos_i);
    pys_d = pra_pkg::PROD_W'(side_i.dy) * pra_pkg::PROD_W'(sin_i);
    pxs_d = pra_pkg::PROD_W'(side_i.dx) * pra_pkg::PROD_W'(sin_i);
    pyc_d = pra_pkg::PROD_W'(side_i.dy) * pra_pkg::PROD_W'(cos_i);
  end

  // stage 2: sums with the rounding half added
  logic                             v2_q;
  logic signed [pra_pkg::SUM_W-1:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [pra_pkg::COORD_WIDTH-1:0] cx2_q, cy2_q;

  always_comb begin
    sx_d = pra_pkg::SUM_W'(pxc_q) + pra_pkg::SUM_W'(pys_q) + pra_pkg::RND_HALF;
    sy_d = pra_pkg::SUM_W'(pyc_q) - pra_pkg::SUM_W'(pxs_q) + pra_pkg::RND_HALF;
  end

  // stage 3: drop the fraction, add the center, clamp
  logic                                   v3_q;
  logic signed [pra_pkg::RND_W-1:0]       rnd_x, rnd_y;
  logic signed [pra_pkg::OUT_W-1:0]       fx, fy;
  logic signed [pra_pkg::COORD_WIDTH-1:0] rx_d, ry_d, rx_q, ry_q;
  logic                                   sat_x, sat_y, sat_q;

  always_comb begin
    rnd_x = signed'(sx_q[pra_pkg::SUM_W-1:pra_pkg::FRAC_W]);
    rnd_y = signed'(sy_q[pra_pkg::SUM_W-1:pra_pkg::FRAC_W]);
    fx    = pra_pkg::OUT_W'(rnd_x) + pra_pkg::OUT_W'(cx2_q);
    fy    = pra_pkg::OUT_W'(rnd_y) + pra_pkg::OUT_W'(cy2_q);
    sat_x = 1'b1;
    sat_y = 1'b1;
    if (fx > pra_pkg::COORD_MAX) begin
      rx_d = pra_pkg::COORD_WIDTH'(pra_pkg::COORD_MAX);
    end else if (fx < pra_pkg::COORD_MIN) begin
      rx_d = pra_pkg::COORD_WIDTH'(pra_pkg::COORD_MIN);
    end else begin
      rx_d  = pra_pkg::COORD_WIDTH'(fx);
      sat_x = 1'b0;
    end
    if (fy > pra_pkg::COORD_MAX) begin
      ry_d = pra_pkg::COORD_WIDTH'(pra_pkg::COORD_MAX);
    end else if (fy < pra_pkg::COORD_MIN) begin
      ry_d = pra_pkg::COORD_WIDTH'(pra_pkg::COORD_MIN);
    end else begin
      ry_d  = pra_pkg::COORD_WIDTH'(fy);
      sat_y = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxc_q <= pxc_d;
      pys_q <= pys_d;
      pxs_q <= pxs_d;
      pyc_q <= pyc_d;
      cx1_q <= side_i.cx;
      cy1_q <= side_i.cy;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      sat_q <= sat_x | sat_y;
    end
  end

  assign valid_o = v3_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

/* rtl/pra_checker.sv */
// ----------------------------------------------------------------------------
// pra_checker
// Port-level checks on the point rotation block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [pra_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input wire [0:0]                    m_axis_tuser
);

  localparam int CW = pra_pkg::COORD_WIDTH;
  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rx, ry;
  assign rx = m_axis_tdata[0 +: CW];
  assign ry = m_axis_tdata[CW +: CW];

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with output empty");

  // a stalled output backs up to the input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready during output stall");

  // the saturation flag means a coordinate sits on a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (rx == MAXV) || (rx == MINV) || (ry == MAXV) || (ry == MINV))
    else $error("saturation flag without clamped coordinate");

endmodule

bind point_rotate_about_center pra_checker u_pra_checker (.*);

`default_nettype wire

/* tb/point_rotate_about_center_tb.sv */
// ----------------------------------------------------------------------------
// point_rotate_about_center_tb
// Streams points, centers and angles into the rotation pipeline. A bit-exact
// model computes each rotated point, and each output transaction is checked
// against it in order. The run covers directed corners, a random mix with
// idle bursts on both sides, a full drain and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module point_rotate_about_center_tb;

  localparam int CW      = pra_pkg::COORD_WIDTH;
  localparam int AW      = pra_pkg::ANGLE_WIDTH;
  localparam int SW      = pra_pkg::S_DATA_W;
  localparam int MW      = pra_pkg::M_DATA_W;
  localparam int DRAIN_CYCLES = 40;

  // 1/64 degree units
  localparam int FULL_TURN = 23040;
  localparam logic signed [AW-1:0] A_0    = 16'sd0;
  localparam logic signed [AW-1:0] A_1    = 16'sd1;
  localparam logic signed [AW-1:0] A_45   = 16'sd2880;
  localparam logic signed [AW-1:0] A_90   = 16'sd5760;
  localparam logic signed [AW-1:0] A_180  = 16'sd11520;
  localparam logic signed [AW-1:0] A_270  = 16'sd17280;
  localparam logic signed [AW-1:0] A_360  = 16'sd23040;
  localparam logic signed [AW-1:0] A_MAX  = 16'sh7FFF;
  localparam logic signed [AW-1:0] A_MIN  = 16'sh8000;

  localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_ZERO = '0;

  // inverse cordic gain, Q1.30
  localparam longint INV_GAIN_Q30 = 64'sh26DD3B6A;

  // atan(2^-k) in binary angle, 2^32 per turn
  localparam longint ATAN_TURN [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [AW-1:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic                 sat;
  } rot_res_t;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [SW-1:0] s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [MW-1:0] m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  rot_res_t    rotations_due [$];
  rot_res_t    got_point;
  rot_res_t    want_point;
  int unsigned fault_cnt = 0;
  bit          idle_on   = 1'b1;

  point_rotate_about_center u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bit-exact rotation: angle reduction, quadrant fold, cordic, rounding, clamp
  function automatic rot_res_t rotate_about_center(input rot_req_t req);
    longint          r;
    longint unsigned theta64;
    logic [31:0]     theta;
    bit              flip;
    longint          xv, yv, zv, tx, ty;
    longint          dx, dy, sx, sy, hi_lim, lo_lim;
    rot_res_t        res;
    r = longint'($signed(req.angle)) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    theta64 = (($unsigned(r) << 32) + FULL_TURN / 2) / FULL_TURN;
    theta = 32'(theta64);
    flip = 1'b0;
    if (theta[31:30] == 2'b01 || theta[31:30] == 2'b10) begin
      theta = theta + 32'h8000_0000;
      flip = 1'b1;
    end
    zv = longint'($signed(theta));
    xv = INV_GAIN_Q30;
    yv = 0;
    for (int i = 0; i < pra_pkg::CORDIC_STAGES; i++) begin
      tx = yv >>> (i % 32);
      ty = xv >>> (i % 32);
      if (zv >= 0) begin
        xv -= tx;
        yv += ty;
        zv -= ATAN_TURN[i % 32];
      end else begin
        xv += tx;
        yv -= ty;
        zv += ATAN_TURN[i % 32];
      end
    end
    if (flip) begin
      xv = -xv;
      yv = -yv;
    end
    dx = longint'(req.px) - longint'(req.cx);
    dy = longint'(req.py) - longint'(req.cy);
    sx = ((dx * xv + dy * yv + (64'sd1 <<< 29)) >>> 30) + longint'(req.cx);
    sy = ((-dx * yv + dy * xv + (64'sd1 <<< 29)) >>> 30) + longint'(req.cy);
    hi_lim = (64'sd1 <<< (CW - 1)) - 1;
    lo_lim = -(64'sd1 <<< (CW - 1));
    res.sat = 1'b0;
    if (sx > hi_lim) begin sx = hi_lim; res.sat = 1'b1; end
    if (sx < lo_lim) begin sx = lo_lim; res.sat = 1'b1; end
    if (sy > hi_lim) begin sy = hi_lim; res.sat = 1'b1; end
    if (sy < lo_lim) begin sy = lo_lim; res.sat = 1'b1; end
    res.rx = CW'(sx);
    res.ry = CW'(sy);
    return res;
  endfunction

  function automatic rot_req_t rand_point();
    rot_req_t    req;
    int unsigned kind;
    int          ang;
    kind      = $urandom_range(0, 99);
    req.px    = CW'($urandom);
    req.py    = CW'($urandom);
    req.cx    = CW'($urandom);
    req.cy    = CW'($urandom);
    req.angle = AW'($urandom);
    if (kind < 80) begin
      // moderate center with a nearby point keeps most results in range
      req.cx = CW'($signed(22'($urandom)));
      req.cy = CW'($signed(22'($urandom)));
      req.px = req.cx + CW'($signed(18'($urandom)));
      req.py = req.cy + CW'($signed(18'($urandom)));
      if (kind >= 65) begin
        // angles around quadrant boundaries, also beyond one turn
        ang = 5760 * int'($urandom_range(0, 10)) - 28800 + int'($urandom_range(0, 4)) - 2;
        req.angle = AW'(ang);
      end
    end else if (kind < 90) begin
      req.px = req.cx;
      req.py = req.cy;
    end else begin
      req.cx = $urandom_range(0, 1) ? C_MAX - CW'($urandom_range(0, 4095))
                                    : C_MIN + CW'($urandom_range(0, 4095));
      req.cy = $urandom_range(0, 1) ? C_MAX - CW'($urandom_range(0, 4095))
                                    : C_MIN + CW'($urandom_range(0, 4095));
      req.px = req.cx + CW'($signed(16'($urandom)));
      req.py = req.cy + CW'($signed(16'($urandom)));
    end
    return req;
  endfunction

  // one transaction; valid stays high only when another one follows at once
  task automatic send_point(input rot_req_t req, input bit more);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.angle, req.cy, req.cx, req.py, req.px};
    do @(posedge clk_i); while (!s_axis_tready);
    rotations_due.push_back(rotate_about_center(req));
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
    // a closing transaction always drops valid and is followed by an idle gap
    if (!more && gap == 0) gap = 1;
    if (!more || gap != 0) s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic test_directed();
    rot_req_t                reqs [$];
    logic signed [CW-1:0]    qx, qy, ox, oy;
    logic signed [AW-1:0]    sweep [$];
    qx = CW'(25600);     // 100.0
    qy = CW'(12928);     // 50.5
    ox = -CW'(5120);     // -20.0
    oy = CW'(7680);      // 30.0
    reqs.push_back('{C_ZERO, C_ZERO, C_ZERO, C_ZERO, A_0});
    reqs.push_back('{C_MAX, C_MAX, C_ZERO, C_ZERO, A_0});
    reqs.push_back('{C_MIN, C_MIN, C_ZERO, C_ZERO, A_180});
    reqs.push_back('{C_MAX, C_MIN, C_ZERO, C_ZERO, A_90});
    reqs.push_back('{C_MAX, C_MIN, C_MIN, C_MAX, A_180});
    reqs.push_back('{C_MIN, C_MAX, C_MAX, C_MIN, A_270});
    // point at center gives the center back
    reqs.push_back('{C_MAX, C_MAX, C_MAX, C_MAX, A_MIN});
    reqs.push_back('{C_MIN, C_MIN, C_MIN, C_MIN, A_MAX});
    reqs.push_back('{ox, oy, ox, oy, A_45});
    sweep = '{A_1, -A_1, A_45, A_90, A_90 - A_1, A_90 + A_1, A_180 - A_1, A_180, A_270,
              A_360, -A_90, -A_360, A_MIN, A_MAX};
    foreach (sweep[i]) reqs.push_back('{qx, qy, ox, oy, sweep[i]});
    foreach (reqs[i]) send_point(reqs[i], i + 1 < reqs.size());
  endtask

  task automatic test_random_stream(input int unsigned count, input bit with_idle);
    for (int unsigned i = 0; i < count; i++) begin
      // alternate stretches with and without idle bursts
      if (i % 64 == 0) idle_on = with_idle && ($urandom_range(0, 3) != 0);
      send_point(rand_point(), i + 1 < count);
    end
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b0;
    for (int i = 0; i < 24; i++) send_point(rand_point(), i < 23);
    while (rotations_due.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 24; i++) send_point(rand_point(), i < 23);
  endtask

  task automatic report_fault(input string what);
    fault_cnt++;
    if (fault_cnt <= 10)
      $display("%s: expected rx=%0d ry=%0d sat=%0b, got rx=%0d ry=%0d sat=%0b", what,
               want_point.rx, want_point.ry, want_point.sat,
               got_point.rx, got_point.ry, got_point.sat);
  endtask

  // output side stalls in bursts while idling is on
  initial begin : out_ready_gen
    int unsigned n;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_point.rx  = m_axis_tdata[CW-1:0];
      got_point.ry  = m_axis_tdata[2*CW-1:CW];
      got_point.sat = m_axis_tuser[0];
      if (rotations_due.size() == 0) begin
        want_point = '0;
        report_fault("unexpected transaction");
      end else begin
        want_point = rotations_due.pop_front();
        if (got_point.rx !== want_point.rx || got_point.ry !== want_point.ry ||
            got_point.sat !== want_point.sat)
          report_fault("mismatch");
      end
    end
  end

  // worst case is far below this: ~1350 items with the longest gaps and stalls
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stream(880, 1'b1);
    test_drain_pause();
    test_random_stream(400, 1'b0);
    while (rotations_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
